@@ sv/quadratic_root_solver_top_defines.svh @@
// Assertion macros for the quadratic root solver.
// Uses the clk and arst_n names of the module that includes this file.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrs: implication check failed");
`define QRS_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("qrs: forbidden condition seen");
`else
`define QRS_ASSERT_IMP(label, ante, cons)
`define QRS_ASSERT_NEVER(label, cond)
`endif
`endif

@@ sv/qrs_pkg.sv @@
// Shared constants, types and helpers for the quadratic root solver.
// No dependencies.
package qrs_pkg;
	localparam int COEF_W = 16;
	localparam int FRAC_BITS = 16;
	localparam int OUT_W = 40;
	localparam int PROD_W = 2 * COEF_W;
	localparam int D_W = 2 * COEF_W + 1;
	localparam int SQ_N = (D_W + 1) / 2 + FRAC_BITS;
	localparam int RAD_W = 2 * SQ_N;
	localparam int SREM_W = SQ_N + 2;
	localparam int NUM_W = SQ_N + 2;
	localparam int DEN_W = COEF_W + 1;
	localparam int SAT_W = (NUM_W + 1 > OUT_W) ? NUM_W + 1 : OUT_W;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_DOUBLE = 2'd1,
		ST_TWO    = 2'd2,
		ST_AZERO  = 2'd3
	} qrs_status_t;

	typedef struct packed {
		qrs_status_t status;
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
	} qrs_meta_t;

	typedef struct packed {
		qrs_status_t status;
		logic neg_p;
		logic neg_m;
	} qrs_dmeta_t;

	localparam logic signed [SAT_W-1:0] OUT_MAX =
		{{(SAT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [SAT_W-1:0] OUT_MIN = ~OUT_MAX;

	function automatic logic [OUT_W-1:0] sat_out(input logic signed [NUM_W:0] v);
		logic signed [SAT_W-1:0] w;
		w = SAT_W'(v);
		if (w > OUT_MAX)
			w = OUT_MAX;
		else if (w < OUT_MIN)
			w = OUT_MIN;
		return w[OUT_W-1:0];
	endfunction
endpackage

@@ sv/qrs_disc.sv @@
// Discriminant front end: two stages, coefficient products then b*b - 4ac.
// Depends on qrs_pkg.
module qrs_disc import qrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  logic signed [COEF_W-1:0] a,
	input  logic signed [COEF_W-1:0] b,
	input  logic signed [COEF_W-1:0] c,
	output logic                     out_vld,
	output logic [D_W-1:0]           d,
	output qrs_meta_t                meta
);
	logic [COEF_W-1:0] ma, mb, mc;
	logic vld_s1, vld_s2;
	logic [PROD_W-1:0] b2_s1, ac_s1;
	logic differ_s1, azero_s1;
	logic signed [COEF_W-1:0] a_s1, b_s1;
	logic [D_W-1:0] b2x, ac4, d_nx;
	logic neg;
	logic [D_W-1:0] d_s2;
	qrs_meta_t meta_s2;

	assign ma = a[COEF_W-1] ? COEF_W'(-a) : COEF_W'(a);
	assign mb = b[COEF_W-1] ? COEF_W'(-b) : COEF_W'(b);
	assign mc = c[COEF_W-1] ? COEF_W'(-c) : COEF_W'(c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b2_s1     <= mb * mb;
			ac_s1     <= ma * mc;
			differ_s1 <= a[COEF_W-1] != c[COEF_W-1];
			azero_s1  <= a == '0;
			a_s1      <= a;
			b_s1      <= b;
		end
	end

	assign b2x = D_W'(b2_s1);
	assign ac4 = D_W'(ac_s1) << 2;
	assign neg = !differ_s1 && (ac4 > b2x);
	assign d_nx = differ_s1 ? b2x + ac4 : b2x - ac4;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2.a <= a_s1;
			meta_s2.b <= b_s1;
			if (azero_s1) begin
				meta_s2.status <= ST_AZERO;
				d_s2 <= '0;
			end else if (neg) begin
				meta_s2.status <= ST_NONE;
				d_s2 <= '0;
			end else begin
				meta_s2.status <= (d_nx == '0) ? ST_DOUBLE : ST_TWO;
				d_s2 <= d_nx;
			end
		end
	end

	assign out_vld = vld_s2;
	assign d = d_s2;
	assign meta = meta_s2;
endmodule

@@ sv/qrs_sqrt.sv @@
// Pipelined digit-by-digit square root of d * 4^FRAC_BITS, one root bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt import qrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [D_W-1:0]  d,
	input  qrs_meta_t       in_meta,
	output logic            out_vld,
	output logic [SQ_N-1:0] root,
	output qrs_meta_t       out_meta
);
	logic              vld_s  [0:SQ_N];
	logic [RAD_W-1:0]  rad_s  [0:SQ_N];
	logic [SREM_W-1:0] rem_s  [0:SQ_N];
	logic [SQ_N-1:0]   root_s [0:SQ_N];
	qrs_meta_t         meta_s [0:SQ_N];

	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = RAD_W'(d) << (2 * FRAC_BITS);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign meta_s[0] = in_meta;

	for (genvar k = 0; k < SQ_N; k++) begin : g_stage
		logic [SREM_W-1:0] rem_sh, trial;
		assign rem_sh = {rem_s[k][SREM_W-3:0], rad_s[k][2*(SQ_N-1-k) +: 2]};
		assign trial  = {root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_s[k];
				meta_s[k+1] <= meta_s[k];
				if (rem_sh >= trial) begin
					rem_s[k+1]  <= rem_sh - trial;
					root_s[k+1] <= {root_s[k][SQ_N-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= rem_sh;
					root_s[k+1] <= {root_s[k][SQ_N-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[SQ_N];
	assign root     = root_s[SQ_N];
	assign out_meta = meta_s[SQ_N];
endmodule

@@ sv/qrs_div.sv @@
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on qrs_pkg.
module qrs_div import qrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num_p,
	input  logic [NUM_W-1:0] num_m,
	input  logic [DEN_W-1:0] den,
	input  qrs_dmeta_t       in_meta,
	output logic             out_vld,
	output logic [NUM_W-1:0] quo_p,
	output logic [NUM_W-1:0] quo_m,
	output qrs_dmeta_t       out_meta
);
	logic             vld_s  [0:NUM_W];
	logic [NUM_W-1:0] np_s   [0:NUM_W];
	logic [NUM_W-1:0] nm_s   [0:NUM_W];
	logic [DEN_W-1:0] rp_s   [0:NUM_W];
	logic [DEN_W-1:0] rm_s   [0:NUM_W];
	logic [DEN_W-1:0] den_s  [0:NUM_W];
	qrs_dmeta_t       meta_s [0:NUM_W];

	// numerator registers shift left; the quotient fills in from the bottom
	assign vld_s[0]  = in_vld;
	assign np_s[0]   = num_p;
	assign nm_s[0]   = num_m;
	assign rp_s[0]   = '0;
	assign rm_s[0]   = '0;
	assign den_s[0]  = den;
	assign meta_s[0] = in_meta;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0] shp, shm;
		logic gep, gem;
		assign shp = {rp_s[k], np_s[k][NUM_W-1]};
		assign shm = {rm_s[k], nm_s[k][NUM_W-1]};
		assign gep = shp >= {1'b0, den_s[k]};
		assign gem = shm >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				meta_s[k+1] <= meta_s[k];
				np_s[k+1]   <= {np_s[k][NUM_W-2:0], gep};
				nm_s[k+1]   <= {nm_s[k][NUM_W-2:0], gem};
				rp_s[k+1]   <= DEN_W'(gep ? shp - {1'b0, den_s[k]} : shp);
				rm_s[k+1]   <= DEN_W'(gem ? shm - {1'b0, den_s[k]} : shm);
			end
		end
	end

	assign out_vld  = vld_s[NUM_W];
	assign quo_p    = np_s[NUM_W];
	assign quo_m    = nm_s[NUM_W];
	assign out_meta = meta_s[NUM_W];
endmodule

@@ sv/quadratic_root_solver_top.sv @@
// Quadratic root solver: real roots of a*x^2 + b*x + c = 0, 16 fractional bits.
// Pipeline order: discriminant, square root, numerator stage, divider, output register.
// Throughput: one transaction per cycle unless stalled; fully pipelined root/divide units.
// A stalled output freezes the whole pipeline; in_stall follows out_stall while out_valid.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers keep no reset.
`include "quadratic_root_solver_top_defines.svh"
module quadratic_root_solver_top import qrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [COEF_W-1:0] coef_a,
	input  logic signed [COEF_W-1:0] coef_b,
	input  logic signed [COEF_W-1:0] coef_c,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               root_status,
	output logic signed [OUT_W-1:0]  root_plus,
	output logic signed [OUT_W-1:0]  root_minus
);
	// Global advance: every stage moves unless the output register holds an
	// untaken transaction. Bubbles move along with data.
	logic en;

	logic           dv;
	logic [D_W-1:0] dd;
	qrs_meta_t      dmeta;

	logic            sv;
	logic [SQ_N-1:0] sroot;
	qrs_meta_t       smeta;

	// numerator stage
	logic signed [NUM_W-1:0] nb, sx, np, nm;
	logic                    vld_s3;
	logic [NUM_W-1:0]        np_s3, nm_s3;
	logic [DEN_W-1:0]        den_s3;
	qrs_dmeta_t              dm_s3;

	logic             qv;
	logic [NUM_W-1:0] qp, qm;
	qrs_dmeta_t       qmeta;

	logic signed [NUM_W:0] qps, qms;

	// output stage
	logic                   vld_s4;
	qrs_status_t            st_s4;
	logic [OUT_W-1:0]       rp_s4, rm_s4;

	assign en       = !(vld_s4 && out_stall);
	assign in_stall = !en;

	qrs_disc u_disc (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in_valid),
		.a(coef_a), .b(coef_b), .c(coef_c),
		.out_vld(dv), .d(dd), .meta(dmeta)
	);

	qrs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(dv), .d(dd), .in_meta(dmeta),
		.out_vld(sv), .root(sroot), .out_meta(smeta)
	);

	// Form -b*2^F +/- s, then split into magnitude and sign for the unsigned divider.
	assign nb = -(NUM_W'($signed(smeta.b)) <<< FRAC_BITS);
	assign sx = $signed(NUM_W'(sroot));
	assign np = nb + sx;
	assign nm = nb - sx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= sv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s3        <= np[NUM_W-1] ? NUM_W'(-np) : NUM_W'(np);
			nm_s3        <= nm[NUM_W-1] ? NUM_W'(-nm) : NUM_W'(nm);
			den_s3       <= smeta.a[COEF_W-1] ? DEN_W'(-$signed(smeta.a)) << 1
			                                  : DEN_W'($signed(smeta.a)) << 1;
			dm_s3.status <= smeta.status;
			// quotient sign: numerator sign xor divisor sign (truncation toward zero)
			dm_s3.neg_p  <= np[NUM_W-1] ^ smeta.a[COEF_W-1];
			dm_s3.neg_m  <= nm[NUM_W-1] ^ smeta.a[COEF_W-1];
		end
	end

	qrs_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.num_p(np_s3), .num_m(nm_s3), .den(den_s3), .in_meta(dm_s3),
		.out_vld(qv), .quo_p(qp), .quo_m(qm), .out_meta(qmeta)
	);

	// Restore the sign and saturate; drop the roots for no-root and a == 0 cases.
	assign qps = qmeta.neg_p ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
	assign qms = qmeta.neg_m ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= qv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s4 <= qmeta.status;
			if (qmeta.status == ST_DOUBLE || qmeta.status == ST_TWO) begin
				rp_s4 <= sat_out(qps);
				rm_s4 <= sat_out(qms);
			end else begin
				rp_s4 <= '0;
				rm_s4 <= '0;
			end
		end
	end

	assign out_valid   = vld_s4;
	assign root_status = st_s4;
	assign root_plus   = $signed(rp_s4);
	assign root_minus  = $signed(rm_s4);

	// Input only stalls because the output register is blocked.
	`QRS_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
	// Without real roots or with a zero leading coefficient both roots read zero.
	`QRS_ASSERT_IMP(a_zero_roots, out_valid && (root_status == ST_NONE || root_status == ST_AZERO), root_plus == '0 && root_minus == '0)
	// A double root gives the same value on both outputs.
	`QRS_ASSERT_IMP(a_double_eq, out_valid && root_status == ST_DOUBLE, root_plus == root_minus)
	// Distinct roots: root_plus never equals root_minus.
	`QRS_ASSERT_NEVER(a_two_distinct, out_valid && root_status == ST_TWO && root_plus == root_minus)
endmodule

@@ tb/sv/tb_quadratic_root_solver_top.sv @@
`timescale 1ns / 100ps
// Testbench for quadratic_root_solver_top: drives random and directed coefficients.
// Depends on qrs_pkg and the solver RTL; predicts roots with a local scoreboard class.

module tb_quadratic_root_solver_top;
	import qrs_pkg::*;

	typedef struct {
		qrs_status_t     status;
		logic [OUT_W-1:0] plus;
		logic [OUT_W-1:0] minus;
	} roots_t;

	// Root predictor and queue of roots awaiting their output transaction.
	class root_scoreboard;
		roots_t pending[$];
		int     errors;

		function new();
			errors = 0;
		endfunction

		// Floor square root of a radicand below 2^126; squares are formed in 128 bits.
		function longint isqrt(logic [127:0] v);
			logic [63:0] res, cand;
			res = '0;
			for (int i = 62; i >= 0; i--) begin
				cand = res | (64'd1 << i);
				if ({64'd0, cand} * {64'd0, cand} <= v)
					res = cand;
			end
			return longint'(res);
		endfunction

		function logic [OUT_W-1:0] clamp(longint v);
			longint hi, lo;
			hi = (64'sd1 <<< (OUT_W - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				v = hi;
			if (v < lo)
				v = lo;
			return v[OUT_W-1:0];
		endfunction

		// Note one accepted input transaction and queue its expected roots.
		function void note_coefs(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
				logic signed [COEF_W-1:0] c);
			roots_t r;
			longint disc, s, nb, den;
			r.status = ST_AZERO;
			r.plus = '0;
			r.minus = '0;
			if (a != 0) begin
				disc = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
				if (disc < 0) begin
					r.status = ST_NONE;
				end else begin
					// disc < 2^33, so the shifted radicand needs up to 65 bits.
					s = isqrt(128'(disc) << (2 * FRAC_BITS));
					nb = -longint'(b) * (64'sd1 <<< FRAC_BITS);
					den = 2 * longint'(a);
					r.status = (disc == 0) ? ST_DOUBLE : ST_TWO;
					r.plus = clamp((nb + s) / den);
					r.minus = clamp((nb - s) / den);
				end
			end
			pending.push_back(r);
		endfunction

		// Compare one output transaction against the oldest expectation.
		function void check_roots(logic [1:0] st, logic [OUT_W-1:0] p, logic [OUT_W-1:0] m);
			roots_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: status %0d", $time, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$display("%0t root_status exp %0d got %0d", $time, e.status, st);
				errors++;
			end
			if (p !== e.plus) begin
				$display("%0t root_plus exp %h got %h", $time, e.plus, p);
				errors++;
			end
			if (m !== e.minus) begin
				$display("%0t root_minus exp %h got %h", $time, e.minus, m);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY = 2 + SQ_N + 1 + NUM_W + 1;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COEF_W-1:0] coef_a = '0, coef_b = '0, coef_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] root_status;
	logic signed [OUT_W-1:0] root_plus, root_minus;

	root_scoreboard sb = new();
	longint cycles = 0;
	bit hold_long = 1'b0;   // force a long receiver hold-off

	always #5 clk = ~clk;

	quadratic_root_solver_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.out_valid(out_valid), .out_stall(out_stall),
		.root_status(root_status), .root_plus(root_plus), .root_minus(root_minus)
	);

	// Watchdog: bail out with a failure if the run never settles.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Check every output transaction at the edge that accepts it.
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_roots(root_status, root_plus, root_minus);

	// Offer one transaction and hold it until accepted; then drop valid if idling follows.
	task automatic send_coefs(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
			logic signed [COEF_W-1:0] c, int gap);
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_coefs(a, b, c);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int draw_gap(int mode);
		// mode 0: no idling; otherwise uniform 0..9
		return (mode == 0) ? 0 : $urandom_range(0, 9);
	endfunction

	// Mostly real-root equations, plus raw full-range coefficients.
	task automatic send_random(int mode);
		logic signed [COEF_W-1:0] a, b, c;
		int kind;
		kind = $urandom_range(0, 9);
		a = COEF_W'($urandom);
		b = COEF_W'($urandom);
		c = COEF_W'($urandom);
		if (kind < 2) begin
			// small magnitudes give exact and double roots
			a = $signed(4'($urandom));
			b = $signed(5'($urandom));
			c = $signed(4'($urandom));
		end else if (kind < 4) begin
			// build a perfect square: a(x-r)^2 -> double root
			a = $signed(6'($urandom));
			b = COEF_W'(-2 * a * $signed(6'($urandom)));
			c = (a != 0) ? COEF_W'((b * b) / (4 * a)) : c;
		end else if (kind < 7 && a != 0 && c != 0) begin
			// opposite signs guarantee a positive discriminant
			if ((a < 0) == (c < 0))
				c = -c;
		end else if (kind == 7) begin
			a = 0;
		end
		send_coefs(a, b, c, draw_gap(mode));
	endtask

	// Receiver: random stall per transaction, with one long hold-off on request.
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_long = 1'b0;
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				wait_n = (cycles % 4000 < 1500) ? 0 : $urandom_range(0, 9);
				out_stall <= (wait_n != 0);
				repeat (wait_n) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
				while (!out_valid && !hold_long) @(posedge clk);
			end
		end
	end

	initial begin
		logic signed [COEF_W-1:0] mx, mn;
		mx = 16'sh7FFF;
		mn = 16'sh8000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero leading coefficient, double and negative cases.
		send_coefs(0, 5, 7, 0);
		send_coefs(0, mn, mx, 0);
		send_coefs(1, -2, 1, 0);
		send_coefs(1, 0, 1, 0);
		send_coefs(1, 0, -1, 0);
		send_coefs(1, 3, 2, 0);
		send_coefs(-1, 0, 4, 0);
		send_coefs(mx, mx, mx, 0);
		send_coefs(mn, mn, mn, 0);
		send_coefs(mn, mx, mx, 0);
		send_coefs(mx, mn, mn, 0);
		send_coefs(1, mn, mn, 0);
		send_coefs(1, mn, mx, 0);
		send_coefs(-1, mn, mx, 0);
		send_coefs(1, mn, 0, 0);
		send_coefs(-1, mx, 0, 0);
		send_coefs(mn, 0, mx, 0);
		send_coefs(2, 4, 2, 0);
		send_coefs(-16'sd1, -16'sd1, -16'sd1, 0);
		send_coefs(16'sh5555, 16'shAAAA, 16'sh5555, 0);
		send_coefs(16'shAAAA, 16'sh5555, 16'shAAAA, 3);

		// Pause until every expected result has come.
		while (sb.pending.size() != 0) @(posedge clk);

		// Long receiver hold-off while the sender keeps offering.
		hold_long = 1'b1;
		for (int i = 0; i < 120; i++)
			send_random(0);

		for (int i = 0; i < 380; i++)
			send_random((i / 60) % 2);
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+sv
sv/qrs_pkg.sv
sv/qrs_disc.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver_top.sv
tb/sv/tb_quadratic_root_solver_top.sv
